// File: design/strs_pkg.sv
`default_nettype none

package strs_pkg;

   localparam int IDX_W  = 11;
   localparam int DATA_W = 32;

   typedef enum logic [1:0] {
      OP_SET   = 2'd0,
      OP_CLEAR = 2'd1,
      OP_ADD   = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LEAF,
      ST_WALK,
      ST_QUERY,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: design/segment_tree_range_sum_core.sv
`default_nettype none
// Point operation (set, clear, add): a leaf read-modify-write, then a one-node-per-cycle
// read-modify-write walk to the root over LEVELS = clog2(SIZE) levels.
// Range query: one tree level per cycle on two read ports. Out-of-range point
// operation or empty query: straight to the done state. One item is in work at a time.
// Reset: synchronous, active high; a clearing pass over all 2 * 2**LEVELS nodes
// zeroes the node memory while req_ready stays low.
module segment_tree_range_sum_core #(
   parameter int unsigned SIZE = 1024
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_ready,
   input  wire strs_pkg::op_type             req_operation,
   input  wire logic [strs_pkg::IDX_W-1:0]   req_index_lo,
   input  wire logic [strs_pkg::IDX_W-1:0]   req_index_hi,
   input  wire logic signed [strs_pkg::DATA_W-1:0] req_value,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_ready,
   output      logic signed [strs_pkg::DATA_W-1:0] rsp_result,
   input  wire logic                         csr_we,
   input  wire logic [strs_pkg::IDX_W-1:0]   csr_wdata
);
   import strs_pkg::*;

   localparam int          LEVELS      = $clog2(SIZE);
   localparam int unsigned LEAVES      = 2 ** LEVELS;
   localparam int          AW          = LEVELS + 1;
   localparam int unsigned DEPTH       = 2 * LEAVES;
   localparam int unsigned RESET_COUNT = (SIZE < 1024) ? SIZE : 1024;

   logic [DATA_W-1:0] mem [0:DEPTH-1];

   state_type         state_ff, state_in;
   op_type            op_ff, op_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [AW-1:0]     l_ff, l_in;
   logic [AW-1:0]     r_ff, r_in;
   logic [AW-1:0]     clr_ff, clr_in;
   logic [DATA_W-1:0] val_ff, val_in;
   logic [DATA_W-1:0] delta_ff, delta_in;
   logic [DATA_W-1:0] sum_ff, sum_in;
   logic [DATA_W-1:0] res_ff, res_in;
   logic              fa_ff, fa_in;
   logic              fb_ff, fb_in;
   logic [IDX_W-1:0]  count_ff, count_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [DATA_W-1:0] rsp_result_ff, rsp_result_in;

   logic [DATA_W-1:0] rd_a_ff, rd_b_ff;
   logic [AW-1:0]     rd_addr_a, rd_addr_b, wr_addr;
   logic              wr_en;
   logic [DATA_W-1:0] wr_data;

   logic              accept;
   logic              point_ok;
   logic [IDX_W-1:0]  lo_c, hi_c;
   logic              empty;
   logic [AW-1:0]     leaf_lo, leaf_qlo, leaf_qhi;
   logic [AW-1:0]     l_step, r_step;
   logic              out_free;
   logic [DATA_W-1:0] new_val;

   assign req_ready  = (state_ff == ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;
   assign out_free   = !rsp_valid_ff || rsp_ready;

   assign point_ok = (req_index_lo != '0) && (req_index_lo <= count_ff);
   assign lo_c     = (req_index_lo == '0) ? IDX_W'(1) : req_index_lo;
   assign hi_c     = (req_index_hi > count_ff) ? count_ff : req_index_hi;
   assign empty    = (lo_c > hi_c);
   assign leaf_lo  = AW'(LEAVES - 1) + AW'(req_index_lo);
   assign leaf_qlo = AW'(LEAVES - 1) + AW'(lo_c);
   assign leaf_qhi = AW'(LEAVES - 1) + AW'(hi_c);
   assign l_step   = AW'(({1'b0, l_ff} + (AW + 1)'(l_ff[0])) >> 1);
   assign r_step   = (r_ff - AW'(!r_ff[0])) >> 1;

   always_comb begin
      case (op_ff)
         OP_SET:   new_val = val_ff;
         OP_CLEAR: new_val = '0;
         default:  new_val = rd_a_ff + val_ff;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: if (clr_ff == '1) state_in = ST_IDLE;
         ST_IDLE: begin
            if (accept) begin
               if (req_operation == OP_QUERY) begin
                  state_in = empty ? ST_DONE : ST_QUERY;
               end else begin
                  state_in = point_ok ? ST_LEAF : ST_DONE;
               end
            end
         end
         ST_LEAF:  state_in = ST_WALK;
         ST_WALK:  if (node_ff == AW'(1)) state_in = ST_DONE;
         ST_QUERY: if (l_ff > r_ff) state_in = ST_DONE;
         ST_DONE:  if (out_free) state_in = ST_IDLE;
         default:  state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      op_in         = op_ff;
      node_in       = node_ff;
      l_in          = l_ff;
      r_in          = r_ff;
      clr_in        = clr_ff;
      val_in        = val_ff;
      delta_in      = delta_ff;
      sum_in        = sum_ff;
      res_in        = res_ff;
      fa_in         = 1'b0;
      fb_in         = 1'b0;
      rd_addr_a     = node_ff;
      rd_addr_b     = r_ff;
      wr_en         = 1'b0;
      wr_addr       = node_ff;
      wr_data       = '0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = clr_ff;
            clr_in  = clr_ff + AW'(1);
         end
         ST_IDLE: begin
            rd_addr_a = leaf_lo;
            if (accept) begin
               op_in   = req_operation;
               val_in  = req_value;
               node_in = leaf_lo;
               l_in    = leaf_qlo;
               r_in    = leaf_qhi;
               sum_in  = '0;
               res_in  = '0;
            end
         end
         ST_LEAF: begin
            wr_en     = 1'b1;
            wr_data   = new_val;
            delta_in  = new_val - rd_a_ff;
            res_in    = (op_ff == OP_CLEAR) ? rd_a_ff : new_val;
            rd_addr_a = node_ff >> 1;
            node_in   = node_ff >> 1;
         end
         ST_WALK: begin
            wr_en     = 1'b1;
            wr_data   = rd_a_ff + delta_ff;
            rd_addr_a = node_ff >> 1;
            node_in   = node_ff >> 1;
         end
         ST_QUERY: begin
            sum_in    = sum_ff + (fa_ff ? rd_a_ff : '0) + (fb_ff ? rd_b_ff : '0);
            rd_addr_a = l_ff;
            rd_addr_b = r_ff;
            if (l_ff <= r_ff) begin
               fa_in = l_ff[0];
               fb_in = !r_ff[0];
               l_in  = l_step;
               r_in  = r_step;
            end else begin
               res_in = sum_in;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = res_ff;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (csr_we) begin
         if (csr_wdata == '0) begin
            count_in = IDX_W'(1);
         end else if (32'(csr_wdata) > SIZE) begin
            count_in = IDX_W'(SIZE);
         end else begin
            count_in = csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= IDX_W'(RESET_COUNT);
         rsp_valid_ff <= 1'b0;
         fa_ff        <= 1'b0;
         fb_ff        <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         fa_ff        <= fa_in;
         fb_ff        <= fb_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      node_ff       <= node_in;
      l_ff          <= l_in;
      r_ff          <= r_in;
      val_ff        <= val_in;
      delta_ff      <= delta_in;
      sum_ff        <= sum_in;
      res_ff        <= res_in;
      rsp_result_ff <= rsp_result_in;
   end

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (state_ff == ST_CLEAR) && !rsp_valid_ff)
      else $error("reset did not start the clearing pass");

   a_bad_point: assert property (@(posedge clock) disable iff (reset)
      accept && (req_operation != OP_QUERY) && !point_ok
      |=> (state_ff == ST_DONE) && (res_ff == '0))
      else $error("out-of-range point operation touched the tree");

   a_walk_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK)
      |-> ($past(state_ff) == ST_LEAF) || ($past(state_ff) == ST_WALK))
      else $error("node walk entered without a leaf update");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_DONE))
      else $error("response raised outside the done state");

endmodule

`default_nettype wire
